// ===== rtl/core/closest_pair_sum_query_macros.svh =====
// Assertion macros used by the checker file cpsq_checker.sv.
`ifndef CLOSEST_PAIR_SUM_QUERY_MACROS_SVH
`define CLOSEST_PAIR_SUM_QUERY_MACROS_SVH
`define CPSQ_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define CPSQ_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/cpsq_pkg.sv =====
// ----------------------------------------------------------------------------
// cpsq_pkg
// Types and codes of the closest pair-sum query block.
// ----------------------------------------------------------------------------
package cpsq_pkg;
  // Width of a store position carried by a token; covers up to 256 entries.
  localparam int IDX_W = 8;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] element_value;
    logic signed [31:0] target_value;
  } cmd_t;

  typedef struct packed {
    logic signed [32:0] closest_sum;
    logic               last;
    logic               empty_res;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT,
    ST_EMIT2
  } state_t;

  // Data that travels down the chain of cells.
  typedef struct packed {
    logic               vld;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] a;
  } tok_t;

  // Best below and above the target, handed from cell to cell.
  typedef struct packed {
    logic               have_lo;
    logic               have_hi;
    logic               hit;
    logic signed [32:0] lo;
    logic signed [32:0] hi;
  } best_t;
endpackage

// ===== rtl/core/cpsq_cell.sv =====
// ----------------------------------------------------------------------------
// cpsq_cell
// One cell: holds one stored value and, as values stream past, forms the
// sums with them and folds them into the running best pair.
// ----------------------------------------------------------------------------
module cpsq_cell
  import cpsq_pkg::*;
#(
  parameter int POS = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic               load,
  input  logic signed [31:0] load_value,
  input  logic               active,
  input  logic signed [32:0] target,
  input  tok_t               tok_in,
  input  best_t              best_in,
  output tok_t               tok_out,
  output best_t              best_out
);
  logic               held;
  logic signed [31:0] val;
  logic signed [32:0] s;
  best_t              b;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end
    if (load) begin
      val <= load_value;
    end
  end

  assign s = 33'(tok_in.a) + 33'(val);

  always_comb begin
    b = best_in;
    if (active && held && tok_in.vld && !best_in.hit &&
        tok_in.idx < IDX_W'(POS)) begin
      if (s == target) begin
        b.hit = 1'b1;
        b.lo  = s;
      end else if (s < target) begin
        if (!b.have_lo || s > b.lo) begin
          b.lo = s;
          b.have_lo = 1'b1;
        end
      end else if (!b.have_hi || s < b.hi) begin
        b.hi = s;
        b.have_hi = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
    end
    tok_out.idx <= tok_in.idx;
    tok_out.a   <= tok_in.a;
    best_out    <= b;
  end
endmodule

// ===== rtl/core/closest_pair_sum_query.sv =====
// ----------------------------------------------------------------------------
// closest_pair_sum_query
// Each stored value sits in a cell of a chain. A query streams every stored
// value into the head of the chain, one per cycle; value i is summed only in
// the cells of later positions, so each pair is summed once. The best sums
// ride along with each token and are merged as tokens leave the chain. Load,
// clear and no-op transfers leave busy low, so one can follow every cycle. A
// query with fewer than two values stored holds busy for one cycle; otherwise
// it holds busy through the scan and drain states, which feed the values
// and empty the chain, and then one emit state, or two when a tie gives two
// results. Results come on strobe for one cycle each and cannot be stalled.
// ----------------------------------------------------------------------------
module closest_pair_sum_query
  import cpsq_pkg::*;
#(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic strobe,
  output res_t result
);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int IW = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;

  state_t             state, state_next;
  logic [CW-1:0]      count;
  logic [CW:0]        step;
  logic signed [32:0] target;
  logic signed [31:0] feed_mem [MAX_ELEMENTS];
  logic signed [31:0] feed_q;
  logic [IDX_W-1:0]   feed_idx;
  logic               feed_vld;
  logic               go;
  logic               is_load;
  best_t              fin;
  best_t              merged;
  logic signed [33:0] dlo;
  logic signed [33:0] dhi;
  tok_t               toks [MAX_ELEMENTS+1];
  best_t              bests [MAX_ELEMENTS+1];

  assign go      = start && !busy;
  assign is_load = go && cmd.opcode == OP_LOAD && count < CW'(MAX_ELEMENTS);
  assign busy    = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (is_load) begin
      feed_mem[count[IW-1:0]] <= cmd.element_value;
    end
    feed_q   <= feed_mem[step[IW-1:0]];
    feed_idx <= IDX_W'(step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_vld <= 1'b0;
    end else begin
      feed_vld <= state == ST_SCAN && step < (CW+1)'(count);
    end
  end

  assign toks[0]  = '{vld: feed_vld, idx: feed_idx, a: feed_q};
  assign bests[0] = '0;

  for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
    cpsq_cell #(.POS(k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (go && cmd.opcode == OP_CLEAR),
      .load      (is_load && count == CW'(k)),
      .load_value(cmd.element_value),
      .active    (state == ST_SCAN || state == ST_DRAIN),
      .target    (target),
      .tok_in    (toks[k]),
      .best_in   (bests[k]),
      .tok_out   (toks[k+1]),
      .best_out  (bests[k+1])
    );
  end

  always_comb begin
    merged = fin;
    if (!fin.hit) begin
      if (bests[MAX_ELEMENTS].hit) begin
        merged.hit = 1'b1;
        merged.lo  = bests[MAX_ELEMENTS].lo;
      end else begin
        if (bests[MAX_ELEMENTS].have_lo &&
            (!fin.have_lo || bests[MAX_ELEMENTS].lo > fin.lo)) begin
          merged.have_lo = 1'b1;
          merged.lo      = bests[MAX_ELEMENTS].lo;
        end
        if (bests[MAX_ELEMENTS].have_hi &&
            (!fin.have_hi || bests[MAX_ELEMENTS].hi < fin.hi)) begin
          merged.have_hi = 1'b1;
          merged.hi      = bests[MAX_ELEMENTS].hi;
        end
      end
    end
  end

  assign dlo = 34'(target) - 34'(fin.lo);
  assign dhi = 34'(fin.hi) - 34'(target);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      step  <= '0;
      fin   <= '0;
    end else begin
      state <= state_next;
      if (go && cmd.opcode == OP_CLEAR) begin
        count <= '0;
      end else if (is_load) begin
        count <= count + 1'b1;
      end
      if (state == ST_IDLE) begin
        step <= '0;
      end else begin
        step <= step + 1'b1;
      end
      if (state == ST_IDLE) begin
        fin <= '0;
      end else if (state == ST_DRAIN && toks[MAX_ELEMENTS].vld) begin
        fin <= merged;
      end
    end
    if (go) begin
      target <= 33'(cmd.target_value);
    end
  end

  // A cell sums a token only when the token's position is below its own, so
  // each pair is summed once and no value is paired with itself.

  always_comb begin
    state_next = state;
    strobe     = 1'b0;
    result     = '0;
    case (state)
      ST_IDLE: begin
        if (go && cmd.opcode == OP_QUERY) begin
          if (count < CW'(2)) begin
            strobe = 1'b0;
            state_next = ST_EMIT;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (step == (CW+1)'(count)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (step == (CW+1)'(MAX_ELEMENTS + 3) + (CW+1)'(count)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        strobe = 1'b1;
        state_next = ST_IDLE;
        if (count < CW'(2)) begin
          result = '{closest_sum: '0, last: 1'b1, empty_res: 1'b1};
        end else if (fin.hit) begin
          result = '{closest_sum: fin.lo, last: 1'b1, empty_res: 1'b0};
        end else if (fin.have_lo && fin.have_hi) begin
          if (dlo == dhi) begin
            result = '{closest_sum: fin.lo, last: 1'b0, empty_res: 1'b0};
            state_next = ST_EMIT2;
          end else if (dlo < dhi) begin
            result = '{closest_sum: fin.lo, last: 1'b1, empty_res: 1'b0};
          end else begin
            result = '{closest_sum: fin.hi, last: 1'b1, empty_res: 1'b0};
          end
        end else begin
          result = '{closest_sum: fin.have_lo ? fin.lo : fin.hi, last: 1'b1,
                     empty_res: 1'b0};
        end
      end
      ST_EMIT2: begin
        strobe = 1'b1;
        result = '{closest_sum: fin.hi, last: 1'b1, empty_res: 1'b0};
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/core/cpsq_checker.sv =====
// ----------------------------------------------------------------------------
// cpsq_checker
// Port-level checks of the closest pair-sum query block.
// ----------------------------------------------------------------------------
`include "closest_pair_sum_query_macros.svh"
module cpsq_checker
  import cpsq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input cmd_t cmd,
  input logic strobe,
  input res_t result
);
  `CPSQ_ASSERT_IMP(a_empty_last, clk, rst, strobe && result.empty_res, result.last)
  `CPSQ_ASSERT_NEXT(a_tie_pair, clk, rst, strobe && !result.last, strobe && result.last)
  `CPSQ_ASSERT_IMP(a_strobe_busy, clk, rst, strobe, busy)
  `CPSQ_ASSERT_NEXT(a_query_busy, clk, rst, start && !busy && cmd.opcode == OP_QUERY, busy)
endmodule

bind closest_pair_sum_query cpsq_checker u_cpsq_checker (.*);

// ===== bench/closest_pair_sum_query_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// closest_pair_sum_query_tb
// Drives load, clear and query commands into the pair-sum query block while
// a behavioral predictor keeps its own copy of the stored values. Every query
// result is compared field by field against the predicted nearest pair sums.
// ----------------------------------------------------------------------------
module closest_pair_sum_query_tb;
  import cpsq_pkg::*;

  localparam int MAX_ELEMENTS = 64;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd;
  logic strobe;
  res_t result;

  closest_pair_sum_query #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .strobe(strobe), .result(result)
  );

  cmd_t pending_cmds[$];
  res_t expected_sums[$];
  logic signed [31:0] model_store[MAX_ELEMENTS];
  int model_count;
  int gap_pct;
  bit hold_off;
  bit errors;
  bit took;
  int cycles;
  int drain_wait;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void queue_cmd(cmd_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  function automatic void queue_res(res_t r);
    expected_sums = {expected_sums, r};
  endfunction

  function automatic cmd_t mk_cmd(op_t op, logic [31:0] e, logic [31:0] t);
    cmd_t c;
    c.opcode = op;
    c.element_value = e;
    c.target_value = t;
    return c;
  endfunction

  function automatic res_t mk_res(logic signed [32:0] s, logic l, logic e);
    res_t r;
    r.closest_sum = s;
    r.last = l;
    r.empty_res = e;
    return r;
  endfunction

  function automatic logic [31:0] rand_value(int span);
    logic [31:0] v;
    case ($urandom_range(4))
      0: v = $urandom;
      1: v = $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                               : 32'h80000000 + $urandom_range(3);
      default: v = $urandom_range(2 * span) - span;
    endcase
    return v;
  endfunction

  task automatic predict_pair_sums(cmd_t c);
    longint tgt, s, lo, hi;
    bit have_lo, have_hi, hit;
    have_lo = 0;
    have_hi = 0;
    hit = 0;
    lo = 0;
    hi = 0;
    case (c.opcode)
      OP_LOAD: begin
        if (model_count < MAX_ELEMENTS) begin
          model_store[model_count] = c.element_value;
          model_count++;
        end
      end
      OP_CLEAR: model_count = 0;
      OP_QUERY: begin
        if (model_count < 2) begin
          queue_res(mk_res(33'sd0, 1'b1, 1'b1));
        end else begin
          tgt = longint'(c.target_value);
          for (int i = 0; i < model_count - 1 && !hit; i++) begin
            for (int j = i + 1; j < model_count && !hit; j++) begin
              s = longint'(model_store[i]) + longint'(model_store[j]);
              if (s == tgt) begin
                hit = 1;
                lo = s;
              end else if (s < tgt) begin
                if (!have_lo || s > lo) lo = s;
                have_lo = 1;
              end else begin
                if (!have_hi || s < hi) hi = s;
                have_hi = 1;
              end
            end
          end
          if (hit) begin
            queue_res(mk_res(lo[32:0], 1'b1, 1'b0));
          end else if (have_lo && have_hi && (tgt - lo == hi - tgt)) begin
            queue_res(mk_res(lo[32:0], 1'b0, 1'b0));
            queue_res(mk_res(hi[32:0], 1'b1, 1'b0));
          end else if (have_lo && (!have_hi || tgt - lo < hi - tgt)) begin
            queue_res(mk_res(lo[32:0], 1'b1, 1'b0));
          end else begin
            queue_res(mk_res(hi[32:0], 1'b1, 1'b0));
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    took = !rst && start && !busy;
    if (took) begin
      predict_pair_sums(cmd);
    end
  end

  // Driver: one transfer per accepted start, gaps drawn from gap_pct.
  always @(negedge clk) begin
    if (!rst) begin
      if (took || !start) begin
        if (pending_cmds.size() > 0 && !hold_off &&
            $urandom_range(99) >= gap_pct) begin
          cmd <= pending_cmds.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be stalled, so every strobe is a transfer.
  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && strobe) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected result transfer: closest_sum %0d", result.closest_sum);
        errors = 1;
      end else begin
        exp_r = expected_sums.pop_front();
        if (result.closest_sum !== exp_r.closest_sum) begin
          $error("closest_sum expected %0d actual %0d",
                 exp_r.closest_sum, result.closest_sum);
          errors = 1;
        end
        if (result.last !== exp_r.last) begin
          $error("last expected %0b actual %0b", exp_r.last, result.last);
          errors = 1;
        end
        if (result.empty_res !== exp_r.empty_res) begin
          $error("empty_res expected %0b actual %0b", exp_r.empty_res, result.empty_res);
          errors = 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || start || busy || expected_sums.size() > 0)
      @(posedge clk);
  endtask

  task automatic add_random_phase(int n);
    int span;
    int loads;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: queue_cmd(mk_cmd(OP_CLEAR, $urandom, $urandom));
        1: queue_cmd(mk_cmd(OP_NONE, $urandom, $urandom));
        2, 3, 4: begin
          // Well-formed set: a clear followed by up to 70 loads.
          span = $urandom_range(1) ? 40 : 1000000;
          loads = $urandom_range(7) == 0 ? $urandom_range(70) : $urandom_range(8);
          queue_cmd(mk_cmd(OP_CLEAR, $urandom, $urandom));
          for (int m = 0; m < loads; m++)
            queue_cmd(mk_cmd(OP_LOAD, rand_value(span), $urandom));
          k += loads + 1;
        end
        5, 6: queue_cmd(mk_cmd(OP_LOAD, rand_value(40), $urandom));
        default: queue_cmd(mk_cmd(OP_QUERY, $urandom,
                                  rand_value($urandom_range(1) ? 80 : 2000000)));
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    gap_pct = 0;
    hold_off = 0;
    errors = 0;
    took = 0;
    cycles = 0;
    model_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty store, one element, ties, exact hit, extremes, overflow.
    queue_cmd(mk_cmd(OP_QUERY, 0, 0));
    queue_cmd(mk_cmd(OP_LOAD, 32'h7fffffff, 0));
    queue_cmd(mk_cmd(OP_QUERY, 0, 32'h80000000));
    queue_cmd(mk_cmd(OP_LOAD, 32'h7fffffff, 0));
    queue_cmd(mk_cmd(OP_QUERY, 0, 32'h80000000));
    queue_cmd(mk_cmd(OP_NONE, 32'hffffffff, 32'hffffffff));
    queue_cmd(mk_cmd(OP_CLEAR, 0, 0));
    queue_cmd(mk_cmd(OP_LOAD, 32'h80000000, 0));
    queue_cmd(mk_cmd(OP_LOAD, 32'h80000000, 0));
    queue_cmd(mk_cmd(OP_QUERY, 0, 32'h7fffffff));
    queue_cmd(mk_cmd(OP_CLEAR, 0, 0));
    queue_cmd(mk_cmd(OP_LOAD, 1, 0));
    queue_cmd(mk_cmd(OP_LOAD, 3, 0));
    queue_cmd(mk_cmd(OP_LOAD, 7, 0));
    queue_cmd(mk_cmd(OP_QUERY, 0, 6));
    queue_cmd(mk_cmd(OP_QUERY, 0, 10));
    queue_cmd(mk_cmd(OP_QUERY, 0, 9));
    queue_cmd(mk_cmd(OP_QUERY, 0, -5));
    queue_cmd(mk_cmd(OP_QUERY, 0, 100));
    queue_cmd(mk_cmd(OP_CLEAR, 0, 0));
    for (int k = 0; k < MAX_ELEMENTS + 2; k++)
      queue_cmd(mk_cmd(OP_LOAD, k - 30, 0));
    queue_cmd(mk_cmd(OP_QUERY, 0, 65));
    queue_cmd(mk_cmd(OP_QUERY, 0, 32'h7fffffff));
    wait_drained();

    // Hold the driver off before the random phases start.
    hold_off = 1;
    repeat (5) @(posedge clk);
    hold_off = 0;

    gap_pct = 28;
    add_random_phase(70);
    wait_drained();
    gap_pct = 64;
    add_random_phase(70);
    wait_drained();
    gap_pct = 0;
    add_random_phase(62);
    wait_drained();

    drain_wait = 0;
    while (drain_wait < 2 * MAX_ELEMENTS + 20) begin
      @(posedge clk);
      drain_wait++;
    end
    if (!errors && expected_sums.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
